// File: design/ktr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_pkg
// shared types, constants and saturating arithmetic for the kalman tracker
// ----------------------------------------------------------------------------
package ktr_pkg;

   localparam int WORD_BITS = 48;
   localparam int FRAC_BITS = 16;
   localparam int CFG_BITS  = 36;
   localparam int CONF_BITS = 23;
   localparam int IDX_BITS  = 2;
   localparam int ROOT_BITS = 24;
   localparam int RAD_BITS  = WORD_BITS - 1;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic        [WORD_BITS-1:0] uword_type;
   typedef logic        [CFG_BITS-1:0]  cfg_type;
   typedef logic        [CONF_BITS-1:0] conf_type;
   typedef logic        [IDX_BITS-1:0]  idx_type;
   typedef logic        [ROOT_BITS-1:0] root_type;
   typedef logic        [RAD_BITS-1:0]  rad_type;

   localparam idx_type CSR_PROCESS_NOISE_VALUE = 2'd0;
   localparam idx_type CSR_PROCESS_NOISE_RATE  = 2'd1;
   localparam idx_type CSR_MEASUREMENT_NOISE   = 2'd2;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam word_type Q00_RESET  = word_type'(64'd10 << FRAC_BITS);
   localparam word_type Q11_RESET  = word_type'(64'd1 << FRAC_BITS);
   localparam word_type R_RESET    = word_type'(64'd500 << FRAC_BITS);
   localparam word_type X0_RESET   = word_type'(64'd1000 << FRAC_BITS);
   localparam word_type P00_RESET  = word_type'(64'd1000000 << FRAC_BITS);
   localparam word_type P11_RESET  = word_type'(64'd1000 << FRAC_BITS);
   localparam word_type VAR_LIMIT  = word_type'(64'd10000 << FRAC_BITS);
   localparam conf_type CONF_FULL  = conf_type'(64'd100 << FRAC_BITS);

   // saturating add or subtract on the word range
   function automatic word_type sat_add(input word_type a, input word_type b,
                                        input logic sub);
      logic signed [WORD_BITS:0] s;
      s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
              : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
      if (s[WORD_BITS] != s[WORD_BITS-1])
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      return s[WORD_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: design/two_state_kalman_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_state_kalman_tracker
// value/rate kalman filter over scalar measurements, saturating fixed point
// ----------------------------------------------------------------------------
// One measurement comes in on the req_ channel; one result (estimate and
// confidence) goes out on the rsp_ channel. A transaction moves when valid is
// high and stall is low. req_stall stays high from the accepted measurement
// until its result has been taken.
// Sequence: the predict adds run through the shared saturating adder, then
// five product-quotients in the multiply-divide unit (shift-add multiply,
// a rounding step, restoring divide), then, if needed, the square root.
// When the innovation variance is not positive the divisions are skipped.
// While the receiver stalls the result holds on rsp_ and no new measurement
// is taken. Reset restores the default noise registers and the initial
// state. csr_ writes are taken in any cycle and should come while idle.
// ----------------------------------------------------------------------------
module two_state_kalman_tracker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  ktr_pkg::word_type    req_measurement,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output ktr_pkg::word_type    rsp_estimate,
   output ktr_pkg::conf_type    rsp_confidence,
   input  wire                  csr_we,
   input  ktr_pkg::idx_type     csr_index,
   input  ktr_pkg::cfg_type     csr_wdata
);
   import ktr_pkg::*;

   typedef enum logic [2:0] {IDLE, ADD, MD_GO, MD_WAIT, CONF, SQ_WAIT, OUT} state_type;

   state_type   state_ff;
   logic [3:0]  add_idx_ff;
   logic [2:0]  md_idx_ff;
   word_type    q00_ff, q11_ff, r_ff;
   word_type    x0_ff, x1_ff, p00_ff, p01_ff, p11_ff;
   word_type    z_ff, pp00_ff, pp01_ff, pp11_ff, s_ff, y_ff;
   conf_type    conf_ff;

   word_type    alu_a, alu_b, alu_y;
   logic        alu_sub;
   word_type    md_a, md_b, md_q;
   logic        md_start, md_done;
   logic        sq_start, sq_done;
   root_type    sq_root;
   logic signed [CONF_BITS+1:0] conf_diff;

   // operand select for the shared saturating adder
   always_comb begin
      alu_a   = pp00_ff;
      alu_b   = p01_ff;
      alu_sub = 1'b0;
      if (state_ff == MD_WAIT) begin
         unique case (md_idx_ff)
            3'd0:    begin alu_a = x0_ff;   alu_b = md_q; end
            3'd1:    begin alu_a = x1_ff;   alu_b = md_q; end
            default: begin alu_a = pp11_ff; alu_b = md_q; alu_sub = 1'b1; end
         endcase
      end else begin
         unique case (add_idx_ff)
            4'd0:    begin alu_a = x0_ff;   alu_b = x1_ff;  end
            4'd1:    begin alu_a = p00_ff;  alu_b = p01_ff; end
            4'd2:    begin alu_a = pp00_ff; alu_b = p01_ff; end
            4'd3:    begin alu_a = pp00_ff; alu_b = p11_ff; end
            4'd4:    begin alu_a = pp00_ff; alu_b = q00_ff; end
            4'd5:    begin alu_a = p01_ff;  alu_b = p11_ff; end
            4'd6:    begin alu_a = p11_ff;  alu_b = q11_ff; end
            4'd7:    begin alu_a = pp00_ff; alu_b = r_ff;   end
            default: begin alu_a = z_ff;    alu_b = x0_ff;  alu_sub = 1'b1; end
         endcase
      end
      alu_y = sat_add(alu_a, alu_b, alu_sub);
   end

   always_comb begin
      unique case (md_idx_ff)
         3'd0:    begin md_a = pp00_ff; md_b = y_ff;    end
         3'd1:    begin md_a = pp01_ff; md_b = y_ff;    end
         3'd2:    begin md_a = pp00_ff; md_b = r_ff;    end
         3'd3:    begin md_a = pp01_ff; md_b = r_ff;    end
         default: begin md_a = pp01_ff; md_b = pp01_ff; end
      endcase
   end

   assign md_start  = state_ff == MD_GO;
   assign sq_start  = state_ff == CONF && p00_ff > 0 && p00_ff < VAR_LIMIT;
   assign conf_diff = $signed({2'b00, CONF_FULL}) - $signed({1'b0, sq_root});

   ktr_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (md_a),
      .b     (md_b),
      .d     (s_ff),
      .done  (md_done),
      .q     (md_q)
   );

   ktr_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ({p00_ff[RAD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         add_idx_ff <= '0;
         md_idx_ff  <= '0;
         q00_ff     <= Q00_RESET;
         q11_ff     <= Q11_RESET;
         r_ff       <= R_RESET;
         x0_ff      <= X0_RESET;
         x1_ff      <= '0;
         p00_ff     <= P00_RESET;
         p01_ff     <= '0;
         p11_ff     <= P11_RESET;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PROCESS_NOISE_VALUE: q00_ff <= word_type'(csr_wdata);
               CSR_PROCESS_NOISE_RATE:  q11_ff <= word_type'(csr_wdata);
               CSR_MEASUREMENT_NOISE:   r_ff   <= word_type'(csr_wdata);
               default: ;
            endcase
         end
         unique case (state_ff)
            IDLE: if (req_valid) begin
               z_ff       <= req_measurement;
               add_idx_ff <= '0;
               state_ff   <= ADD;
            end
            ADD: begin
               add_idx_ff <= add_idx_ff + 4'd1;
               unique case (add_idx_ff)
                  4'd0: x0_ff   <= alu_y;
                  4'd5: pp01_ff <= alu_y;
                  4'd6: pp11_ff <= alu_y;
                  4'd7: s_ff    <= alu_y;
                  4'd8: y_ff    <= alu_y;
                  default: pp00_ff <= alu_y;
               endcase
               if (add_idx_ff == 4'd8) begin
                  md_idx_ff <= '0;
                  if (s_ff > 0) begin
                     state_ff <= MD_GO;
                  end else begin
                     // update skipped, keep the prediction
                     p00_ff   <= pp00_ff;
                     p01_ff   <= pp01_ff;
                     p11_ff   <= pp11_ff;
                     state_ff <= CONF;
                  end
               end
            end
            MD_GO: state_ff <= MD_WAIT;
            MD_WAIT: if (md_done) begin
               md_idx_ff <= md_idx_ff + 3'd1;
               state_ff  <= MD_GO;
               unique case (md_idx_ff)
                  3'd0: x0_ff  <= alu_y;
                  3'd1: x1_ff  <= alu_y;
                  3'd2: p00_ff <= md_q;
                  3'd3: p01_ff <= md_q;
                  default: begin
                     p11_ff   <= alu_y;
                     state_ff <= CONF;
                  end
               endcase
            end
            CONF: begin
               if (p00_ff <= 0) begin
                  conf_ff  <= CONF_FULL;
                  state_ff <= OUT;
               end else if (p00_ff >= VAR_LIMIT) begin
                  conf_ff  <= '0;
                  state_ff <= OUT;
               end else begin
                  state_ff <= SQ_WAIT;
               end
            end
            SQ_WAIT: if (sq_done) begin
               conf_ff  <= conf_diff[CONF_BITS+1] ? '0 : conf_diff[CONF_BITS-1:0];
               state_ff <= OUT;
            end
            OUT: if (!rsp_stall) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_stall      = state_ff != IDLE;
   assign rsp_valid      = state_ff == OUT;
   assign rsp_estimate   = x0_ff;
   assign rsp_confidence = conf_ff;

endmodule
`default_nettype wire

// File: design/ktr_muldiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_muldiv
// round(a*b/d) with ties away from zero, saturated; shift-add then restoring
// ----------------------------------------------------------------------------
module ktr_muldiv (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  ktr_pkg::word_type a,
   input  ktr_pkg::word_type b,
   input  ktr_pkg::word_type d,
   output logic              done,
   output ktr_pkg::word_type q
);
   import ktr_pkg::*;

   typedef enum logic [2:0] {IDLE, MUL, ROUND, DIV, FIN} state_type;

   localparam int PROD_BITS = 2 * WORD_BITS;

   state_type                state_ff;
   logic [6:0]               cnt_ff;
   logic                     neg_ff, ovf_ff;
   uword_type                ma_ff, mb_ff, d_ff, rem_ff, quo_ff;
   logic [PROD_BITS-1:0]     acc_ff;
   word_type                 q_ff;

   logic [WORD_BITS:0]       psum;
   logic [WORD_BITS:0]       trial;
   logic                     qbit;
   uword_type                limit, qsat;

   always_comb begin
      psum  = {1'b0, acc_ff[PROD_BITS-1:WORD_BITS]} + {1'b0, (mb_ff[0] ? ma_ff : '0)};
      trial = {rem_ff, acc_ff[PROD_BITS-1]};
      qbit  = trial >= {1'b0, d_ff};
      limit = neg_ff ? uword_type'(WORD_MAX) + uword_type'(1) : uword_type'(WORD_MAX);
      qsat  = (ovf_ff || quo_ff > limit) ? limit : quo_ff;
   end

   always_ff @(posedge clock) begin
      done <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            IDLE: if (start) begin
               neg_ff   <= a[WORD_BITS-1] != b[WORD_BITS-1];
               ma_ff    <= a[WORD_BITS-1] ? uword_type'(-a) : uword_type'(a);
               mb_ff    <= b[WORD_BITS-1] ? uword_type'(-b) : uword_type'(b);
               d_ff     <= uword_type'(d);
               acc_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= MUL;
            end
            MUL: begin
               acc_ff <= {psum, acc_ff[WORD_BITS-1:1]};
               mb_ff  <= mb_ff >> 1;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(WORD_BITS - 1)) state_ff <= ROUND;
            end
            ROUND: begin
               acc_ff   <= acc_ff + {{WORD_BITS{1'b0}}, d_ff >> 1};
               rem_ff   <= '0;
               quo_ff   <= '0;
               ovf_ff   <= 1'b0;
               cnt_ff   <= '0;
               state_ff <= DIV;
            end
            DIV: begin
               rem_ff <= qbit ? uword_type'(trial - {1'b0, d_ff}) : trial[WORD_BITS-1:0];
               acc_ff <= acc_ff << 1;
               quo_ff <= {quo_ff[WORD_BITS-2:0], qbit};
               ovf_ff <= ovf_ff | quo_ff[WORD_BITS-1];
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(PROD_BITS - 1)) state_ff <= FIN;
            end
            FIN: begin
               q_ff     <= neg_ff ? word_type'(-qsat) : word_type'(qsat);
               done     <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign q = q_ff;

endmodule
`default_nettype wire

// File: design/ktr_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_isqrt
// floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module ktr_isqrt (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  ktr_pkg::rad_type   radicand,
   output logic               done,
   output ktr_pkg::root_type  root
);
   import ktr_pkg::*;

   typedef enum logic {IDLE, ITER} state_type;

   state_type    state_ff;
   rad_type      v_ff, bit_ff;
   uword_type    res_ff;
   uword_type    trial;

   assign trial = res_ff + uword_type'(bit_ff);

   always_ff @(posedge clock) begin
      done <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         unique case (state_ff)
            IDLE: if (start) begin
               v_ff     <= radicand;
               res_ff   <= '0;
               bit_ff   <= rad_type'(1) << (RAD_BITS - 1);
               state_ff <= ITER;
            end
            ITER: begin
               if (uword_type'(v_ff) >= trial) begin
                  v_ff   <= v_ff - rad_type'(trial);
                  res_ff <= (res_ff >> 1) + uword_type'(bit_ff);
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  done     <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign root = res_ff[ROOT_BITS-1:0];

endmodule
`default_nettype wire

// File: design/ktr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_checker
// port-level checks on the kalman tracker, bound to the top level
// ----------------------------------------------------------------------------
module ktr_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_stall,
   input wire                rsp_valid,
   input wire                rsp_stall,
   input ktr_pkg::word_type  rsp_estimate,
   input ktr_pkg::conf_type  rsp_confidence
);
   import ktr_pkg::*;

   // a pending result keeps new measurements out
   a_busy_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result pending while input open");

   // an accepted transaction closes the input on the next cycle
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("input not closed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_estimate)
                                    && $stable(rsp_confidence)))
      else $error("stalled result changed");

   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_confidence <= CONF_FULL)) else $error("confidence range");

endmodule

bind two_state_kalman_tracker ktr_checker u_ktr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_estimate   (rsp_estimate),
   .rsp_confidence (rsp_confidence)
);
`default_nettype wire

// File: verif/two_state_kalman_tracker_tb.sv
// ----------------------------------------------------------------------------
// two_state_kalman_tracker_tb
// Self-checking bench for the value/rate kalman tracker. Each measurement
// that the block takes is run through a local fixed-point model of the filter.
// The model keeps its own copy of the state and the noise registers. Every
// result that the block returns is checked field by field against the oldest
// predicted result. Stimulus is a directed set, a burst under extreme noise,
// then tracking runs with random noise over several noise settings. Both
// sides of the handshake idle at random, except in one quiet phase.
// ----------------------------------------------------------------------------
module two_state_kalman_tracker_tb;
   import ktr_pkg::*;

   typedef struct {
      word_type estimate;
      conf_type confidence;
   } track_result_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_measurement = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_estimate;
   conf_type rsp_confidence;
   logic     csr_we = 1'b0;
   idx_type  csr_index = CSR_PROCESS_NOISE_VALUE;
   cfg_type  csr_wdata = '0;

   // local copy of filter state and noise registers
   word_type q_value, q_rate, r_meas;
   word_type x_val, x_rate, p_vv, p_vr, p_rr;

   word_type         pending_meas[$];
   track_result_type expected_results[$];
   int               error_count = 0;
   bit               req_taken = 0;
   bit               rsp_taken = 0;
   bit               quiet = 0;
   int               send_gap = 0;
   int               hold_left = 0;

   two_state_kalman_tracker i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_estimate    (rsp_estimate),
      .rsp_confidence  (rsp_confidence),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic word_type sadd(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_BITS-1:0];
   endfunction

   function automatic word_type ssub(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_BITS-1:0];
   endfunction

   // round(a*b/d) ties away from zero, saturated; d > 0
   function automatic word_type gain_ratio(input word_type a, input word_type b,
                                           input word_type d);
      logic         neg;
      logic [127:0] ma, mb, num, quo, lim;
      neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
      ma = a[WORD_BITS-1] ? 128'(-longint'(a)) : 128'(longint'(a));
      mb = b[WORD_BITS-1] ? 128'(-longint'(b)) : 128'(longint'(b));
      num = ma * mb + 128'(longint'(d) >>> 1);
      quo = num / 128'(longint'(d));
      lim = neg ? (128'd1 << (WORD_BITS-1)) : ((128'd1 << (WORD_BITS-1)) - 1);
      if (quo > lim) quo = lim;
      return neg ? word_type'(-longint'(quo[63:0])) : word_type'(quo[63:0]);
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   task automatic reset_filter();
      q_value = Q00_RESET;
      q_rate = Q11_RESET;
      r_meas = R_RESET;
      x_val = X0_RESET;
      x_rate = '0;
      p_vv = P00_RESET;
      p_vr = '0;
      p_rr = P11_RESET;
   endtask

   task automatic track_step(input word_type z);
      word_type         pvv, pvr, prr, s, y;
      longint           conf;
      track_result_type res;
      x_val = sadd(x_val, x_rate);
      pvv = sadd(p_vv, p_vr);
      pvv = sadd(pvv, p_vr);
      pvv = sadd(pvv, p_rr);
      pvv = sadd(pvv, q_value);
      pvr = sadd(p_vr, p_rr);
      prr = sadd(p_rr, q_rate);
      s = sadd(pvv, r_meas);
      if (s > 0) begin
         y = ssub(z, x_val);
         x_val = sadd(x_val, gain_ratio(pvv, y, s));
         x_rate = sadd(x_rate, gain_ratio(pvr, y, s));
         p_vv = gain_ratio(pvv, r_meas, s);
         p_vr = gain_ratio(pvr, r_meas, s);
         p_rr = ssub(prr, gain_ratio(pvr, pvr, s));
      end else begin
         p_vv = pvv;
         p_vr = pvr;
         p_rr = prr;
      end
      if (p_vv <= 0) begin
         conf = CONF_FULL;
      end else if (p_vv >= VAR_LIMIT) begin
         conf = 0;
      end else begin
         conf = longint'(CONF_FULL)
              - longint'(floor_root(64'(longint'(p_vv)) << FRAC_BITS));
         if (conf < 0) conf = 0;
      end
      res.estimate = x_val;
      res.confidence = conf_type'(conf);
      expected_results.push_back(res);
   endtask

   // driver: accept detection at the rising edge, drive at the falling edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         track_step(req_measurement);
         req_taken = 1;
      end
   end

   always @(negedge clock) begin
      if (req_taken) begin
         req_taken = 0;
         req_valid = 1'b0;
         send_gap = quiet ? 0 : $urandom_range(0, 13);
      end else if (!req_valid && !reset) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_meas.size() > 0) begin
            req_measurement = pending_meas.pop_front();
            req_valid = 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      track_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1;
         if (expected_results.size() == 0) begin
            $error("unexpected transaction: estimate %0d confidence %0d",
                   rsp_estimate, rsp_confidence);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_estimate !== want.estimate) begin
               $error("estimate: expected %0d actual %0d", want.estimate, rsp_estimate);
               error_count++;
            end
            if (rsp_confidence !== want.confidence) begin
               $error("confidence: expected %0d actual %0d",
                      want.confidence, rsp_confidence);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 0;
         hold_left = quiet ? 0 : $urandom_range(0, 13);
      end
      rsp_stall = (hold_left > 0);
      if (hold_left > 0) hold_left--;
   end

   task automatic write_csr(input idx_type idx, input cfg_type val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_PROCESS_NOISE_VALUE: q_value = word_type'(val);
         CSR_PROCESS_NOISE_RATE:  q_rate = word_type'(val);
         CSR_MEASUREMENT_NOISE:   r_meas = word_type'(val);
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_meas.size() > 0 || req_valid || expected_results.size() > 0) begin
         @(negedge clock);
      end
   endtask

   function automatic word_type any_word();
      return word_type'({$urandom, $urandom});
   endfunction

   // a noisy track with random start and rate, with occasional wild samples
   task automatic queue_track(input int count);
      longint pos, step, spread;
      pos = longint'($urandom_range(0, 4000000)) - 2000000;
      pos = pos <<< FRAC_BITS;
      step = (longint'($urandom_range(0, 2000)) - 1000) <<< (FRAC_BITS - 4);
      spread = longint'($urandom_range(1, 60)) <<< FRAC_BITS;
      for (int i = 0; i < count; i++) begin
         pos += step;
         if ($urandom_range(0, 15) == 0) begin
            pending_meas.push_back(any_word());
         end else begin
            pending_meas.push_back(word_type'(pos + longint'($urandom_range(0, 2 * spread))
                                              - spread));
         end
      end
   endtask

   localparam cfg_type CFG_TOP = '1;

   initial begin
      cfg_type noise_q0 [7] = '{36'd0, CFG_TOP, 36'd655360, 36'd1, 36'd6553600,
                                36'd65536, 36'd100};
      cfg_type noise_q1 [7] = '{36'd0, CFG_TOP, 36'd0, 36'd65536, 36'd1,
                                36'd655, 36'd40000};
      cfg_type noise_r  [7] = '{36'd1, CFG_TOP, 36'd32768000, 36'd65536, CFG_TOP,
                                36'd1, 36'd300000};
      reset_filter();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, signs and a steady target
      pending_meas.push_back(WORD_MAX);
      pending_meas.push_back(WORD_MIN);
      pending_meas.push_back('0);
      pending_meas.push_back('1);
      pending_meas.push_back(word_type'(1));
      pending_meas.push_back(X0_RESET);
      for (int i = 0; i < 10; i++) pending_meas.push_back(X0_RESET);
      pending_meas.push_back(WORD_MAX);
      pending_meas.push_back(WORD_MAX);
      pending_meas.push_back(WORD_MIN);
      pending_meas.push_back(word_type'(48'h5555_5555_5555));
      pending_meas.push_back(word_type'(48'haaaa_aaaa_aaaa));
      drain();

      // extreme noise sends variances into saturation
      write_csr(CSR_PROCESS_NOISE_VALUE, CFG_TOP);
      write_csr(CSR_PROCESS_NOISE_RATE, CFG_TOP);
      write_csr(CSR_MEASUREMENT_NOISE, 36'd1);
      for (int i = 0; i < 4; i++) pending_meas.push_back(any_word());
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         write_csr(CSR_PROCESS_NOISE_VALUE, noise_q0[ph]);
         write_csr(CSR_PROCESS_NOISE_RATE, noise_q1[ph]);
         write_csr(CSR_MEASUREMENT_NOISE, noise_r[ph]);
         quiet = (ph == 3);
         for (int t = 0; t < 3; t++) queue_track(50);
         drain();
      end
      quiet = 0;

      repeat (800) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(12 * 1100 * 4000);
      $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
design/ktr_pkg.sv
design/ktr_muldiv.sv
design/ktr_isqrt.sv
design/two_state_kalman_tracker.sv
design/ktr_checker.sv
verif/two_state_kalman_tracker_tb.sv
